// ===== src/spd_pkg.sv =====
// Package for the shortest path distances block: sizes, command and status codes.
// No dependencies.
package spd_pkg;
	localparam int MaxVertices = 1024;
	localparam int MaxEdges = 8192;
	localparam int WeightBits = 8;
	localparam int LengthBits = 24;
	localparam int VtxBits = $clog2(MaxVertices);
	localparam int EdgeBits = $clog2(MaxEdges);
	localparam int CntBits = EdgeBits + 1;
	localparam int EdgeWordBits = 2 * VtxBits + WeightBits;
	localparam int VcBits = 11;
	localparam logic [LengthBits-1:0] LenMax = '1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD = 2'd1,
		CMD_RUN = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [VtxBits-1:0] tail_vertex;
		logic [VtxBits-1:0] head_vertex;
		logic [WeightBits-1:0] edge_weight;
		logic [VtxBits-1:0] vertex;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [LengthBits-1:0] path_length;
		logic reachable;
		logic saturated;
	} out_item_t;
endpackage

// ===== src/spd_if.sv =====
// Valid/ready channel interface carrying one item of a given payload type.
// Depends on spd_pkg for the payload types.
interface spd_in_if import spd_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spd_out_if import spd_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/spd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module spd_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/shortest_path_distances_top.sv =====
// Shortest path distances (Dijkstra) over a loaded edge list, one shared saturating adder.
// Clear and add items go straight to the result; a read first reads the vertex memory.
// A run clears every vertex word, then per settled vertex does a minimum scan over the
// vertices and a sweep over the loaded edges, then a last scan and the result, which is
// held until taken; each memory has one read port, so scans and sweeps read one word at a time.
// arst_n clears control state and edge count; vertices read as unreached until the first run.
module shortest_path_distances_top import spd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [VcBits-1:0] cfg_wdata,
	spd_in_if.sink in_ch,
	spd_out_if.source out_ch
);
	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_READ = 10'b0000000010,
		S_INIT = 10'b0000000100,
		S_SCAN = 10'b0000001000,
		S_SCANW = 10'b0000010000,
		S_PICK = 10'b0000100000,
		S_EDGE = 10'b0001000000,
		S_RELAX = 10'b0010000000,
		S_RELW = 10'b0100000000,
		S_OUT = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [VcBits-1:0] vcount_q;
	logic [CntBits-1:0] loaded_q;
	logic ran_q;
	in_item_t item_q;
	out_item_t res_q;
	logic [VtxBits:0] idx_q;
	logic [CntBits-1:0] eidx_q;
	logic [VtxBits-1:0] u_q;
	logic [LengthBits-1:0] ulen_q;
	logic found_q;
	logic [VtxBits-1:0] cand_v_q;
	logic [LengthBits-1:0] cand_len_q;
	logic [VtxBits-1:0] rd_v_q;
	logic pend_q;

	// Vertex word: reached, settled, length.
	localparam int VW = LengthBits + 2;
	logic vwe;
	logic [VtxBits-1:0] vwaddr, vraddr;
	logic [VW-1:0] vwdata, vrdata;
	logic ewe;
	logic [EdgeBits-1:0] ewaddr, eraddr;
	logic [EdgeWordBits-1:0] ewdata, erdata;

	spd_ram #(.Width(VW), .Depth(MaxVertices)) u_vram (
		.clk, .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(vraddr), .rdata(vrdata)
	);
	spd_ram #(.Width(EdgeWordBits), .Depth(MaxEdges)) u_eram (
		.clk, .we(ewe), .waddr(ewaddr), .wdata(ewdata), .raddr(eraddr), .rdata(erdata)
	);

	logic [VtxBits:0] nv;
	assign nv = (vcount_q > VcBits'(MaxVertices)) ? (VtxBits+1)'(MaxVertices)
		: (VtxBits+1)'(vcount_q);

	logic v_reached, v_settled;
	logic [LengthBits-1:0] v_len;
	assign v_reached = vrdata[VW-1];
	assign v_settled = vrdata[VW-2];
	assign v_len = vrdata[LengthBits-1:0];

	logic [VtxBits-1:0] e_tail, e_head;
	logic [WeightBits-1:0] e_w;
	assign {e_tail, e_head, e_w} = erdata;

	// Shared adder with saturation.
	logic [LengthBits:0] sum;
	logic [LengthBits-1:0] cand_sat;
	assign sum = {1'b0, ulen_q} + (LengthBits+1)'(e_w);
	assign cand_sat = sum[LengthBits] ? LenMax : sum[LengthBits-1:0];

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data = res_q;

	// Memory addressing.
	always_comb begin
		vwe = 1'b0;
		vwaddr = idx_q[VtxBits-1:0];
		vwdata = {2'b00, LenMax};
		vraddr = idx_q[VtxBits-1:0];
		ewe = 1'b0;
		ewaddr = loaded_q[EdgeBits-1:0];
		ewdata = {in_ch.data.tail_vertex, in_ch.data.head_vertex, in_ch.data.edge_weight};
		eraddr = eidx_q[EdgeBits-1:0];
		unique case (state_q)
			S_IDLE: begin
				vraddr = in_ch.data.vertex;
				if (in_ch.valid && in_ch.data.cmd == CMD_ADD
						&& {1'b0, in_ch.data.tail_vertex} < nv
						&& {1'b0, in_ch.data.head_vertex} < nv
						&& loaded_q < CntBits'(MaxEdges))
					ewe = 1'b1;
			end
			S_INIT: begin
				vwe = 1'b1;
				if (idx_q[VtxBits-1:0] == item_q.vertex) vwdata = {2'b10, LengthBits'(0)};
			end
			S_PICK: begin
				vwe = found_q;
				vwaddr = cand_v_q;
				vwdata = {2'b11, cand_len_q};
			end
			S_RELAX: vraddr = e_head;
			S_RELW: begin
				vwaddr = rd_v_q;
				vwdata = {2'b10, cand_len_q};
				vwe = pend_q && !v_settled && (!v_reached || cand_len_q < v_len);
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcount_q <= VcBits'(MaxVertices);
			loaded_q <= '0;
			ran_q <= 1'b0;
		end else begin
			if (cfg_we) vcount_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					item_q <= in_ch.data;
					res_q <= '0;
					unique case (in_ch.data.cmd)
						CMD_CLEAR: begin
							loaded_q <= '0;
							state_q <= S_OUT;
						end
						CMD_ADD: begin
							state_q <= S_OUT;
							if ({1'b0, in_ch.data.tail_vertex} >= nv
									|| {1'b0, in_ch.data.head_vertex} >= nv)
								res_q.status <= ST_RANGE;
							else if (loaded_q >= CntBits'(MaxEdges))
								res_q.status <= ST_FULL;
							else loaded_q <= loaded_q + 1'b1;
						end
						CMD_RUN: begin
							if ({1'b0, in_ch.data.vertex} >= nv) begin
								res_q.status <= ST_RANGE;
								state_q <= S_OUT;
							end else begin
								ran_q <= 1'b1;
								idx_q <= '0;
								state_q <= S_INIT;
							end
						end
						default: begin
							if ({1'b0, in_ch.data.vertex} >= nv) begin
								res_q.status <= ST_RANGE;
								state_q <= S_OUT;
							end else state_q <= S_READ;
						end
					endcase
				end
				S_READ: begin
					if (ran_q && v_reached) begin
						res_q.path_length <= v_len;
						res_q.reachable <= 1'b1;
						res_q.saturated <= (v_len == LenMax);
					end
					state_q <= S_OUT;
				end
				// Clear every vertex word, source set to zero.
				S_INIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (VtxBits+1)'(MaxVertices - 1)) begin
						idx_q <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				// Scan for least unsettled reached vertex, one per cycle.
				S_SCAN: begin
					rd_v_q <= idx_q[VtxBits-1:0];
					idx_q <= idx_q + 1'b1;
					state_q <= S_SCANW;
				end
				S_SCANW: begin
					if (v_reached && !v_settled && (!found_q || v_len < cand_len_q)) begin
						found_q <= 1'b1;
						cand_v_q <= rd_v_q;
						cand_len_q <= v_len;
					end
					if (idx_q >= nv) state_q <= S_PICK;
					else begin
						rd_v_q <= idx_q[VtxBits-1:0];
						idx_q <= idx_q + 1'b1;
					end
				end
				S_PICK: begin
					if (!found_q) state_q <= S_OUT;
					else begin
						u_q <= cand_v_q;
						ulen_q <= cand_len_q;
						eidx_q <= '0;
						state_q <= S_EDGE;
					end
				end
				// Edge sweep: read edge, then head vertex, then relax.
				S_EDGE: begin
					if (eidx_q >= loaded_q) begin
						idx_q <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end else state_q <= S_RELAX;
				end
				S_RELAX: begin
					rd_v_q <= e_head;
					cand_len_q <= cand_sat;
					pend_q <= (e_tail == u_q) && ({1'b0, e_head} < nv);
					eidx_q <= eidx_q + 1'b1;
					state_q <= S_RELW;
				end
				S_RELW: state_q <= S_EDGE;
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks.
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CntBits'(MaxEdges)) else $error("edge count overflow");
	a_noout: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("busy while result pending");
endmodule
